FILE: hdl/positional_list_insert_delete_core_macros.svh
// assertion macros for the positional list core
`ifndef POSITIONAL_LIST_INSERT_DELETE_CORE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PLI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pli_pkg.sv
// shared constants and types of the positional list core
package pli_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [VALUE_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

endpackage

FILE: hdl/pli_store.sv
// entry memory: one write port, one read port with registered read data
module pli_store (
  input  logic                              clk,
  input  pli_pkg::mem_req_t                 req,
  output logic [pli_pkg::VALUE_W-1:0]       rdata
);

  logic [pli_pkg::VALUE_W-1:0] mem [pli_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

FILE: hdl/positional_list_insert_delete_core.sv
// top level of the positional list core: control sequencer, count and result register
//
// channel | dir | payload
// in_     | in  | tuser: opcode; tdata: position, entry_value
// out_    | out | tuser: status; tdata: read_value, actual_position, current_length
// cfg_    | in  | data: list_capacity
//
// insert moves the entries at and above position up one slot before it writes, delete reads
// the entry and moves those above it down one slot; the entry memory moves one entry per cycle.
// rst_n empties the list and sets the capacity to 64; the memory itself is not cleared.
// a new request is taken whenever the sequencer is idle, even while a result waits.
// a finished result waits in the sequencer until the output register is free.
`include "positional_list_insert_delete_core_macros.svh"

module positional_list_insert_delete_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [7:0] position, [39:8] entry_value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] read_value, [37:32] actual_position,
                                  // [44:38] current_length, [47:45] zero
  output logic [1:0]  out_tuser,  // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int AW = pli_pkg::ADDR_W;
  localparam int CW = pli_pkg::CNT_W;
  localparam int VW = pli_pkg::VALUE_W;
  localparam int PW = pli_pkg::POS_W;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SHIFT_UP = 6'b000010,
    S_INS_WR   = 6'b000100,
    S_RD       = 6'b001000,
    S_SHIFT_DN = 6'b010000,
    S_DONE     = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [6:0]        cap_r;
  logic [1:0]        op_r, op_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [VW-1:0]     val_r, val_nxt;
  logic [CW-1:0]     cur_r, cur_nxt;
  logic              lastrd_r, lastrd_nxt;
  logic              lastfirst_r, lastfirst_nxt;
  logic [AW-1:0]     lastaddr_r, lastaddr_nxt;
  logic [1:0]        res_status_r, res_status_nxt;
  logic [VW-1:0]     res_value_r, res_value_nxt;
  logic [AW-1:0]     res_pos_r, res_pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [VW-1:0]     out_value_r, out_value_nxt;
  logic [AW-1:0]     out_pos_r, out_pos_nxt;
  logic [CW-1:0]     out_len_r, out_len_nxt;

  pli_pkg::mem_req_t mreq;
  logic [VW-1:0]     rdata;

  logic              accept;
  logic [1:0]        in_op;
  logic [PW-1:0]     in_pos;
  logic [VW-1:0]     in_val;
  logic [6:0]        eff_cap;
  logic              is_full;
  logic              is_empty;
  logic              is_range;
  logic [AW-1:0]     clamp_pos;

  pli_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign in_op  = in_tuser[1:0];
  assign in_pos = in_tdata[PW-1:0];
  assign in_val = in_tdata[PW+VW-1:PW];

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign eff_cap   = (cap_r > 7'(pli_pkg::DEPTH)) ? 7'(pli_pkg::DEPTH) : cap_r;
  assign is_full   = (count_r >= eff_cap);
  assign is_empty  = (count_r == '0);
  assign is_range  = ({1'b0, in_pos} >= (PW + 1)'(count_r));
  // insert past the end lands at the end
  assign clamp_pos = ({1'b0, in_pos} > (PW + 1)'(count_r)) ? AW'(count_r) : AW'(in_pos);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    lastrd_nxt     = lastrd_r;
    lastfirst_nxt  = lastfirst_r;
    lastaddr_nxt   = lastaddr_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    res_pos_nxt    = res_pos_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_len_nxt    = out_len_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    mreq           = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt         = in_op;
          val_nxt        = in_val;
          res_status_nxt = pli_pkg::ST_OK;
          res_value_nxt  = '0;
          res_pos_nxt    = '0;
          lastrd_nxt     = 1'b0;
          state_nxt      = S_DONE;
          case (in_op)
            pli_pkg::OP_INSERT: begin
              if (is_full) begin
                res_status_nxt = pli_pkg::ST_FULL;
              end else begin
                pos_nxt     = clamp_pos;
                res_pos_nxt = clamp_pos;
                cur_nxt     = count_r;
                state_nxt   = S_SHIFT_UP;
              end
            end
            pli_pkg::OP_GET, pli_pkg::OP_DELETE: begin
              if (is_empty) begin
                res_status_nxt = pli_pkg::ST_EMPTY;
              end else if (is_range) begin
                res_status_nxt = pli_pkg::ST_RANGE;
              end else begin
                pos_nxt   = AW'(in_pos);
                state_nxt = S_RD;
              end
            end
            pli_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // walk down from the top, moving each entry one slot up
      S_SHIFT_UP: begin
        if (lastrd_r) begin
          mreq.we    = 1'b1;
          mreq.waddr = lastaddr_r + AW'(1);
          mreq.wdata = rdata;
        end
        if (cur_r != CW'(pos_r)) begin
          mreq.re      = 1'b1;
          mreq.raddr   = AW'(cur_r - CW'(1));
          lastrd_nxt   = 1'b1;
          lastaddr_nxt = AW'(cur_r - CW'(1));
          cur_nxt      = cur_r - CW'(1);
        end else begin
          lastrd_nxt = 1'b0;
          state_nxt  = S_INS_WR;
        end
      end

      S_INS_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = pos_r;
        mreq.wdata = val_r;
        count_nxt  = count_r + CW'(1);
        state_nxt  = S_DONE;
      end

      S_RD: begin
        mreq.re       = 1'b1;
        mreq.raddr    = pos_r;
        lastrd_nxt    = 1'b1;
        lastfirst_nxt = 1'b1;
        lastaddr_nxt  = pos_r;
        cur_nxt       = CW'(pos_r) + CW'(1);
        state_nxt     = S_SHIFT_DN;
      end

      // first read is the result, later ones move one slot down
      S_SHIFT_DN: begin
        if (lastrd_r) begin
          if (lastfirst_r) begin
            res_value_nxt = rdata;
          end else begin
            mreq.we    = 1'b1;
            mreq.waddr = lastaddr_r - AW'(1);
            mreq.wdata = rdata;
          end
        end
        lastfirst_nxt = 1'b0;
        if (op_r == pli_pkg::OP_DELETE && cur_r < count_r) begin
          mreq.re      = 1'b1;
          mreq.raddr   = AW'(cur_r);
          lastrd_nxt   = 1'b1;
          lastaddr_nxt = AW'(cur_r);
          cur_nxt      = cur_r + CW'(1);
        end else begin
          lastrd_nxt = 1'b0;
          if (op_r == pli_pkg::OP_DELETE) begin
            count_nxt = count_r - CW'(1);
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_pos_nxt    = res_pos_r;
          out_len_nxt    = count_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= 7'd64;
      lastrd_r    <= 1'b0;
      lastfirst_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      lastrd_r    <= lastrd_nxt;
      lastfirst_r <= lastfirst_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    lastaddr_r   <= lastaddr_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    res_pos_r    <= res_pos_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_len_r, out_pos_r, out_value_r};

  `PLI_ASSERT_NXT(a_accept_starts, accept, state_r != S_IDLE, "request left sequencer idle")
  `PLI_ASSERT_IMP(a_no_addr_clash, mreq.we && mreq.re, mreq.waddr != mreq.raddr, "entry clash")
  `PLI_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(pli_pkg::DEPTH), "entry count above depth")
  `PLI_ASSERT_IMP(a_idle_no_read, state_r == S_IDLE, !lastrd_r, "read still in flight while idle")

endmodule
